>>> rtl/core/wpe_pkg.sv
package wpe_pkg;

    // Window arithmetic is bounded by the 9-bit registers, so 12 signed bits cover it.
    localparam int WIN_W = 12;
    localparam int LIM_W = 9;
    localparam int IN_W  = 24;
    localparam int OUT_W = 24;

    localparam logic [1:0] OP_SCHED   = 2'd0;
    localparam logic [1:0] OP_MARK    = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    localparam logic [1:0] MODE_FWD  = 2'd0;
    localparam logic [1:0] MODE_BWD  = 2'd1;
    localparam logic [1:0] MODE_CENT = 2'd2;

    localparam logic [1:0] REG_LIMIT = 2'd0;
    localparam logic [1:0] REG_COUNT = 2'd1;
    localparam logic [1:0] REG_MODE  = 2'd2;

    typedef struct packed {
        logic                    fwd;
        logic [LIM_W-1:0]        size;
        logic signed [WIN_W-1:0] pos;
        logic signed [WIN_W-1:0] wbeg;
        logic signed [WIN_W-1:0] wend;
        logic signed [WIN_W-1:0] lo;
        logic signed [WIN_W-1:0] hi;
    } win_t;

endpackage

>>> rtl/core/wpe_ram.sv
module wpe_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_reg <= mem_reg[raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/wpe_window.sv
module wpe_window (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [wpe_pkg::LIM_W-1:0] pos,
    input  logic [wpe_pkg::LIM_W-1:0] cnt,
    input  logic [wpe_pkg::LIM_W-1:0] lim,
    input  logic                      fwd,
    output logic                      win_valid,
    output wpe_pkg::win_t             win
);

    localparam int W = wpe_pkg::WIN_W;
    localparam logic signed [W-1:0] ONE = W'(1);

    logic [3:0] vld_reg;

    logic [wpe_pkg::LIM_W-1:0] s1_pos_reg, s1_cnt_reg, s1_lim_reg, s1_size_reg;
    logic                      s1_fwd_reg;

    logic signed [W-1:0] p1, c1, l1, sz1, half1, fend1;
    logic signed [W-1:0] s2_p_reg, s2_c_reg, s2_l_reg, s2_b_reg, s2_e_reg;
    logic [wpe_pkg::LIM_W-1:0] s2_size_reg;
    logic                s2_fwd_reg;

    logic signed [W-1:0] sz2;
    logic signed [W-1:0] s3_p_reg, s3_beg_reg, s3_end_reg;
    logic [wpe_pkg::LIM_W-1:0] s3_size_reg;
    logic                s3_fwd_reg;

    wpe_pkg::win_t win_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], start};
        end
    end

    // Stage 1: clamp the position to the source count and size the window.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            s1_pos_reg  <= (pos > cnt) ? cnt : pos;
            s1_cnt_reg  <= cnt;
            s1_lim_reg  <= lim;
            s1_size_reg <= (lim < cnt) ? lim : cnt;
            s1_fwd_reg  <= fwd;
        end
    end

    always_comb
    begin
        p1    = $signed(W'(s1_pos_reg));
        c1    = $signed(W'(s1_cnt_reg));
        l1    = $signed(W'(s1_lim_reg));
        sz1   = $signed(W'(s1_size_reg));
        half1 = $signed(W'(s1_size_reg >> 1));
        fend1 = p1 + l1;
    end

    // Stage 2: raw bounds. Centered end is pos - size/2 + size - 1.
    always_ff @(posedge clk)
    begin
        if (vld_reg[0])
        begin
            s2_p_reg    <= p1;
            s2_c_reg    <= c1;
            s2_l_reg    <= l1;
            s2_size_reg <= s1_size_reg;
            s2_fwd_reg  <= s1_fwd_reg;
            s2_b_reg    <= p1 - half1;
            if (s1_fwd_reg)
            begin
                s2_e_reg <= (fend1 >= c1) ? c1 : fend1;
            end
            else
            begin
                s2_e_reg <= p1 + sz1 - half1 - ONE;
            end
        end
    end

    assign sz2 = $signed(W'(s2_size_reg));

    // Stage 3: forward start bound, or shift the centered window into range.
    always_ff @(posedge clk)
    begin
        if (vld_reg[1])
        begin
            s3_p_reg    <= s2_p_reg;
            s3_size_reg <= s2_size_reg;
            s3_fwd_reg  <= s2_fwd_reg;
            if (s2_fwd_reg)
            begin
                s3_beg_reg <= s2_e_reg - s2_l_reg - ONE;
                s3_end_reg <= s2_e_reg;
            end
            else if (s2_b_reg[W-1])
            begin
                s3_beg_reg <= '0;
                s3_end_reg <= sz2 - ONE;
            end
            else if (s2_e_reg >= s2_c_reg)
            begin
                s3_beg_reg <= s2_c_reg - sz2;
                s3_end_reg <= s2_c_reg - ONE;
            end
            else
            begin
                s3_beg_reg <= s2_b_reg;
                s3_end_reg <= s2_e_reg;
            end
        end
    end

    // Stage 4: the area that counts as inside the window for eviction.
    always_ff @(posedge clk)
    begin
        if (vld_reg[2])
        begin
            win_reg.fwd  <= s3_fwd_reg;
            win_reg.size <= s3_size_reg;
            win_reg.pos  <= s3_p_reg;
            win_reg.wbeg <= s3_beg_reg;
            win_reg.wend <= s3_end_reg;
            win_reg.lo   <= s3_beg_reg + ONE;
            win_reg.hi   <= s3_end_reg - ONE;
        end
    end

    assign win_valid = vld_reg[3];
    assign win       = win_reg;

endmodule

>>> rtl/core/window_prefetch_evict_policy.sv
// Mark and release read the map entry and write it back; one out of range goes straight to the
// result. Clear writes every map entry. A schedule request waits for the window, then checks the
// search candidates in turn (up to 2 * window + 1 centered, up to the window forward, then back
// below the position) and, on a full map, sweeps every entry for the eviction. Backward mode finds nothing.
// One request is in work at a time; a finished result waits in the output register.
// After reset the whole map is cleared with s_axis_tready low.
module window_prefetch_evict_policy #(
    parameter int MAX_ENTRIES = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // position [8:0], entry_index [16:9], zero fill above
    input  logic [wpe_pkg::IN_W-1:0]  s_axis_tdata,
    // opcode [1:0]
    input  logic [1:0]                s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // load_found [0], load_index [8:1], evict_found [9], evict_index [17:10], zero fill above
    output logic [wpe_pkg::OUT_W-1:0] m_axis_tdata,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [wpe_pkg::LIM_W-1:0] cfg_data
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int TW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (IW + 2 > 12) ? IW + 2 : 12;
    localparam int W  = wpe_pkg::WIN_W;
    localparam int LW = wpe_pkg::LIM_W;
    localparam logic [IW-1:0] LAST_ADDR = IW'(MAX_ENTRIES - 1);
    localparam logic signed [W-1:0] ONE = W'(1);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_RMW    = 3'd2;
    localparam logic [2:0] ST_CLEAR  = 3'd3;
    localparam logic [2:0] ST_WIN    = 3'd4;
    localparam logic [2:0] ST_SEARCH = 3'd5;
    localparam logic [2:0] ST_EVICT  = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [IW-1:0] clr_addr_reg, clr_addr_next;

    logic [LW-1:0] limit_reg, count_reg;
    logic [1:0]    mode_reg;

    logic [1:0]    op_reg, op_next;
    logic [7:0]    ent_reg, ent_next;
    logic [TW-1:0] total_reg, total_next;

    logic                gen_active_reg, gen_active_next;
    logic                gen_phase_reg, gen_phase_next;
    logic signed [W-1:0] gen_k_reg, gen_k_next;
    logic [LW:0]         gen_i_reg, gen_i_next;
    logic                chk_valid_reg, chk_valid_next;
    logic signed [W-1:0] chk_k_reg, chk_k_next;

    logic                 ev_run_reg, ev_run_next;
    logic [IW-1:0]        ev_addr_reg, ev_addr_next;
    logic                 ev_rd_reg, ev_rd_next;
    logic [IW-1:0]        ev_rd_i_reg, ev_rd_i_next;
    logic                 dv_reg, dv_next;
    logic signed [AW-1:0] d_reg, d_next;
    logic [IW-1:0]        d_i_reg, d_i_next;
    logic                 best_valid_reg, best_valid_next;
    logic [IW-1:0]        best_reg, best_next;
    logic signed [AW-1:0] dmax_reg, dmax_next;

    logic       res_lf_reg, res_lf_next;
    logic [7:0] res_li_reg, res_li_next;
    logic       res_ef_reg, res_ef_next;
    logic [7:0] res_ei_reg, res_ei_next;

    logic                     m_valid_reg, m_valid_next;
    logic [wpe_pkg::OUT_W-1:0] m_data_reg, m_data_next;

    logic          ram_we, ram_re;
    logic [IW-1:0] ram_waddr, ram_raddr;
    logic [0:0]    ram_wdata, ram_rdata;

    logic          win_start, win_valid;
    wpe_pkg::win_t win;

    logic [LW-1:0]        cnt_eff;
    logic                 in_accept;
    logic [1:0]           in_op;
    logic [7:0]           in_ent;
    logic                 total_full;
    logic signed [W-1:0]  half_k, cent_k;
    logic signed [AW-1:0] iv, lo_x, hi_x, area_gap;

    assign cnt_eff = (AW'(count_reg) > AW'(MAX_ENTRIES)) ? LW'(MAX_ENTRIES) : count_reg;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_op  = s_axis_tuser;
    assign in_ent = s_axis_tdata[16:9];
    assign total_full = (AW'(total_reg) >= AW'(limit_reg)) && (total_reg != '0);

    assign win_start = in_accept && (in_op == wpe_pkg::OP_SCHED)
                       && (mode_reg != wpe_pkg::MODE_BWD);

    // Centered candidate order: pos, pos, pos-1, pos+1, pos-2, ...
    assign half_k = $signed(W'(gen_i_reg[LW:1]));
    assign cent_k = gen_i_reg[0] ? win.pos + half_k : win.pos - half_k;

    assign iv   = $signed(AW'(ev_rd_i_reg));
    assign lo_x = AW'(win.lo);
    assign hi_x = AW'(win.hi);
    assign area_gap = (iv < lo_x) ? lo_x - iv : ((iv > hi_x) ? iv - hi_x : '0);

    wpe_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (win_start),
        .pos       (s_axis_tdata[LW-1:0]),
        .cnt       (cnt_eff),
        .lim       (limit_reg),
        .fwd       (mode_reg == wpe_pkg::MODE_FWD),
        .win_valid (win_valid),
        .win       (win)
    );

    wpe_ram #(
        .WIDTH (1),
        .DEPTH (MAX_ENTRIES)
    ) u_map (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (ram_re),
        .raddr   (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LW'(256);
            count_reg <= '0;
            mode_reg  <= wpe_pkg::MODE_CENT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wpe_pkg::REG_LIMIT: limit_reg <= cfg_data;
                wpe_pkg::REG_COUNT: count_reg <= cfg_data;
                wpe_pkg::REG_MODE:  mode_reg  <= cfg_data[1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        op_next         = op_reg;
        ent_next        = ent_reg;
        total_next      = total_reg;
        gen_active_next = gen_active_reg;
        gen_phase_next  = gen_phase_reg;
        gen_k_next      = gen_k_reg;
        gen_i_next      = gen_i_reg;
        chk_valid_next  = 1'b0;
        chk_k_next      = chk_k_reg;
        ev_run_next     = ev_run_reg;
        ev_addr_next    = ev_addr_reg;
        ev_rd_next      = 1'b0;
        ev_rd_i_next    = ev_rd_i_reg;
        dv_next         = 1'b0;
        d_next          = d_reg;
        d_i_next        = d_i_reg;
        best_valid_next = best_valid_reg;
        best_next       = best_reg;
        dmax_next       = dmax_reg;
        res_lf_next     = res_lf_reg;
        res_li_next     = res_li_reg;
        res_ef_next     = res_ef_reg;
        res_ei_next     = res_ei_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = clr_addr_reg;
        ram_wdata       = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = IW'(in_ent);

        unique case (state_reg)
            ST_INIT,
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    clr_addr_next = '0;
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_DONE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + IW'(1);
                end
            end

            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next     = in_op;
                    ent_next    = in_ent;
                    res_lf_next = 1'b0;
                    res_li_next = '0;
                    res_ef_next = 1'b0;
                    res_ei_next = '0;
                    unique case (in_op)
                        wpe_pkg::OP_MARK:
                        begin
                            if ({1'b0, in_ent} < cnt_eff)
                            begin
                                ram_re     = 1'b1;
                                state_next = ST_RMW;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        wpe_pkg::OP_RELEASE:
                        begin
                            if (AW'(in_ent) < AW'(MAX_ENTRIES))
                            begin
                                ram_re     = 1'b1;
                                state_next = ST_RMW;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        wpe_pkg::OP_CLEAR:
                        begin
                            clr_addr_next = '0;
                            total_next    = '0;
                            state_next    = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = (mode_reg == wpe_pkg::MODE_BWD) ? ST_DONE : ST_WIN;
                        end
                    endcase
                end
            end

            ST_RMW:
            begin
                ram_waddr = IW'(ent_reg);
                if (op_reg == wpe_pkg::OP_MARK && !ram_rdata[0])
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = 1'b1;
                    total_next = total_reg + TW'(1);
                end
                else if (op_reg == wpe_pkg::OP_RELEASE && ram_rdata[0])
                begin
                    ram_we     = 1'b1;
                    total_next = total_reg - TW'(1);
                end
                state_next = ST_DONE;
            end

            ST_WIN:
            begin
                if (win_valid)
                begin
                    gen_active_next = 1'b1;
                    gen_phase_next  = 1'b0;
                    gen_k_next      = win.pos;
                    gen_i_next      = '0;
                    state_next      = ST_SEARCH;
                end
            end

            ST_SEARCH:
            begin
                if (chk_valid_reg && !ram_rdata[0])
                begin
                    res_lf_next = 1'b1;
                    res_li_next = 8'(chk_k_reg);
                    if (total_full)
                    begin
                        ev_run_next     = 1'b1;
                        ev_addr_next    = '0;
                        best_valid_next = 1'b0;
                        dmax_next       = '0;
                        state_next      = ST_EVICT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (gen_active_reg)
                begin
                    ram_raddr = IW'($unsigned(gen_k_reg));
                    if (win.fwd)
                    begin
                        if (!gen_phase_reg)
                        begin
                            if (gen_k_reg < win.wend)
                            begin
                                ram_re         = 1'b1;
                                chk_valid_next = 1'b1;
                                chk_k_next     = gen_k_reg;
                                gen_k_next     = gen_k_reg + ONE;
                            end
                            else
                            begin
                                gen_phase_next = 1'b1;
                                gen_k_next     = win.pos - ONE;
                            end
                        end
                        else if (gen_k_reg > win.wbeg && !gen_k_reg[W-1])
                        begin
                            ram_re         = 1'b1;
                            chk_valid_next = 1'b1;
                            chk_k_next     = gen_k_reg;
                            gen_k_next     = gen_k_reg - ONE;
                        end
                        else
                        begin
                            gen_active_next = 1'b0;
                        end
                    end
                    else
                    begin
                        ram_raddr      = IW'($unsigned(cent_k));
                        ram_re         = 1'b1;
                        chk_valid_next = (cent_k >= win.wbeg) && (cent_k <= win.wend);
                        chk_k_next     = cent_k;
                        if (gen_i_reg == {win.size, 1'b0})
                        begin
                            gen_active_next = 1'b0;
                        end
                        else
                        begin
                            gen_i_next = gen_i_reg + (LW + 1)'(1);
                        end
                    end
                end
                else if (!chk_valid_reg)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_EVICT:
            begin
                // Sweep: issue a read, then compute the distance, then compare.
                if (ev_run_reg)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = ev_addr_reg;
                    ev_rd_next   = 1'b1;
                    ev_rd_i_next = ev_addr_reg;
                    if (ev_addr_reg == LAST_ADDR)
                    begin
                        ev_run_next = 1'b0;
                    end
                    else
                    begin
                        ev_addr_next = ev_addr_reg + IW'(1);
                    end
                end
                dv_next  = ev_rd_reg && ram_rdata[0];
                d_next   = area_gap;
                d_i_next = ev_rd_i_reg;
                if (dv_reg && (!best_valid_reg || d_reg > dmax_reg))
                begin
                    best_valid_next = 1'b1;
                    best_next       = d_i_reg;
                    dmax_next       = d_reg;
                end
                if (!ev_run_reg && !ev_rd_reg && !dv_reg)
                begin
                    if (best_valid_reg && dmax_reg != '0)
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = best_reg;
                        total_next  = total_reg - TW'(1);
                        res_ef_next = 1'b1;
                        res_ei_next = 8'(best_reg);
                    end
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = wpe_pkg::OUT_W'({res_ei_reg, res_ef_reg,
                                                    res_li_reg, res_lf_reg});
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            clr_addr_reg   <= '0;
            total_reg      <= '0;
            gen_active_reg <= 1'b0;
            chk_valid_reg  <= 1'b0;
            ev_run_reg     <= 1'b0;
            ev_rd_reg      <= 1'b0;
            dv_reg         <= 1'b0;
            best_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            total_reg      <= total_next;
            gen_active_reg <= gen_active_next;
            chk_valid_reg  <= chk_valid_next;
            ev_run_reg     <= ev_run_next;
            ev_rd_reg      <= ev_rd_next;
            dv_reg         <= dv_next;
            best_valid_reg <= best_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        ent_reg       <= ent_next;
        gen_phase_reg <= gen_phase_next;
        gen_k_reg     <= gen_k_next;
        gen_i_reg     <= gen_i_next;
        chk_k_reg     <= chk_k_next;
        ev_addr_reg   <= ev_addr_next;
        ev_rd_i_reg   <= ev_rd_i_next;
        d_reg         <= d_next;
        d_i_reg       <= d_i_next;
        best_reg      <= best_next;
        dmax_reg      <= dmax_next;
        res_lf_reg    <= res_lf_next;
        res_li_reg    <= res_li_next;
        res_ef_reg    <= res_ef_next;
        res_ei_reg    <= res_ei_next;
        m_data_reg    <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

>>> rtl/core/wpe_checker.sv
module wpe_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [wpe_pkg::OUT_W-1:0] m_axis_tdata
);

    logic [1:0] pending_reg, pending_next;
    logic       in_acc, out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign pending_next = pending_reg + 2'(in_acc) - 2'(out_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // An eviction only happens together with a load, and unused indexes are zero.
    a_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[17:1] == '0)
        else $error("result without load carries eviction or index");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> pending_reg != 2'd0)
        else $error("result delivered with no request outstanding");

    // One request in work at a time, at most one more result waiting.
    a_one_open: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> pending_reg <= 2'd1)
        else $error("request accepted while another is still in work");

endmodule

bind window_prefetch_evict_policy wpe_checker u_wpe_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int N_ENTRIES = 256;
    localparam int STALL_LIMIT = 20000;
    localparam int LONG_HOLD = 1500;
    // Mode value 3 is decoded like the centered mode.
    localparam logic [1:0] MODE_CENT_ALT = 2'd3;

    typedef struct {
        bit       load_found;
        bit [7:0] load_index;
        bit       evict_found;
        bit [7:0] evict_index;
    } placement_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [wpe_pkg::IN_W-1:0]  s_axis_tdata = '0;
    logic [1:0]                s_axis_tuser = wpe_pkg::OP_SCHED;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [wpe_pkg::OUT_W-1:0] m_axis_tdata;
    logic                      cfg_we = 1'b0;
    logic [1:0]                cfg_index = wpe_pkg::REG_LIMIT;
    logic [wpe_pkg::LIM_W-1:0] cfg_data = '0;

    // Shadow of the block's registers and loaded map.
    int                limit_reg = 256;
    int                count_reg = 0;
    logic [1:0]        mode_reg = wpe_pkg::MODE_CENT;
    bit [N_ENTRIES-1:0] resident = '0;
    int                resident_total = 0;

    placement_t        expected_placements[$];
    placement_t        want;
    int                error_count = 0;
    int                source_idle_pct = 0;
    int                sink_idle_pct = 0;
    int                holds_asked = 0;
    int                holds_served = 0;
    int                stall_left = 0;
    int                quiet_cycles = 0;

    window_prefetch_evict_policy #(
        .MAX_ENTRIES (N_ENTRIES)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit is_resident(int i);
        if (i < 0 || i >= N_ENTRIES)
            return 1'b0;
        return resident[i];
    endfunction

    // Applies one request to the shadow state and returns the placement decision.
    function automatic placement_t predict_placement(logic [1:0] op, int pos, int ent);
        placement_t res;
        int cnt, lim, lo_edge, hi_edge, hit, victim, far, gap, span, k, off;
        res = '{default: 0};
        cnt = (count_reg > N_ENTRIES) ? N_ENTRIES : count_reg;
        lim = limit_reg;
        lo_edge = 0;
        hi_edge = 0;
        hit = -1;
        victim = -1;
        if (op == wpe_pkg::OP_MARK)
        begin
            if (ent < cnt && !resident[ent])
            begin
                resident[ent] = 1'b1;
                resident_total++;
            end
            return res;
        end
        if (op == wpe_pkg::OP_RELEASE)
        begin
            if (resident[ent])
            begin
                resident[ent] = 1'b0;
                resident_total--;
            end
            return res;
        end
        if (op == wpe_pkg::OP_CLEAR)
        begin
            resident = '0;
            resident_total = 0;
            return res;
        end
        if (mode_reg == wpe_pkg::MODE_BWD)
            return res;
        if (pos > cnt)
            pos = cnt;
        if (mode_reg == wpe_pkg::MODE_FWD)
        begin
            hi_edge = (pos + lim >= cnt) ? cnt : pos + lim;
            for (int i = pos; i < hi_edge && hit < 0; i++)
                if (!is_resident(i))
                    hit = i;
            lo_edge = hi_edge - lim - 1;
            for (int i = pos - 1; i > lo_edge && i >= 0 && hit < 0; i--)
                if (!is_resident(i))
                    hit = i;
        end
        else
        begin
            span = (lim < cnt) ? lim : cnt;
            lo_edge = pos - span / 2;
            hi_edge = lo_edge + span - 1;
            if (lo_edge < 0)
            begin
                hi_edge -= lo_edge;
                lo_edge = 0;
            end
            else if (hi_edge >= cnt)
            begin
                lo_edge -= hi_edge - cnt + 1;
                hi_edge = cnt - 1;
            end
            // Outward search: pos, pos, pos-1, pos+1, pos-2, ...
            for (int i = 0; i <= span * 2 && hit < 0; i++)
            begin
                off = (i / 2) * ((i % 2) ? 1 : -1);
                k = pos + off;
                if (k >= lo_edge && k <= hi_edge && !is_resident(k))
                    hit = k;
            end
        end
        if (hit < 0)
            return res;
        if (resident_total >= lim && resident_total > 0)
        begin
            far = 0;
            for (int i = 0; i < N_ENTRIES; i++)
            begin
                if (resident[i])
                begin
                    if (i < lo_edge + 1)
                        gap = lo_edge + 1 - i;
                    else if (i > hi_edge - 1)
                        gap = i - (hi_edge - 1);
                    else
                        gap = 0;
                    if (victim < 0 || gap > far)
                    begin
                        victim = i;
                        far = gap;
                    end
                end
            end
            if (victim >= 0 && far != 0)
            begin
                resident[victim] = 1'b0;
                resident_total--;
            end
            else
                victim = -1;
        end
        res.load_found = 1'b1;
        res.load_index = hit[7:0];
        if (victim >= 0)
        begin
            res.evict_found = 1'b1;
            res.evict_index = victim[7:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        error_count++;
    endtask

    // Offers one request, waits for acceptance and records the expected placement.
    task automatic send_request(input logic [1:0] op, input int pos, input int ent,
                                output placement_t res);
        if (source_idle_pct != 0 && $urandom_range(99) < source_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < source_idle_pct)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {{(wpe_pkg::IN_W - 17){1'b0}}, ent[7:0], pos[8:0]};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        res = predict_placement(op, pos, ent);
        expected_placements = {expected_placements, res};
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_placements.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input int lim, input int cnt, input logic [1:0] mode);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= wpe_pkg::REG_LIMIT;
        cfg_data <= lim[wpe_pkg::LIM_W-1:0];
        @(posedge clk);
        cfg_index <= wpe_pkg::REG_COUNT;
        cfg_data <= cnt[wpe_pkg::LIM_W-1:0];
        @(posedge clk);
        cfg_index <= wpe_pkg::REG_MODE;
        cfg_data <= {{(wpe_pkg::LIM_W - 2){1'b0}}, mode};
        @(posedge clk);
        cfg_we <= 1'b0;
        limit_reg = lim;
        count_reg = cnt;
        mode_reg = mode;
    endtask

    function automatic int pick_position(int cnt);
        int r;
        r = $urandom_range(99);
        if (r < 85)
            return $urandom_range(cnt);
        if (r < 95)
            return $urandom_range(256);
        return 256;
    endfunction

    task automatic test_directed_forward();
        placement_t res;
        configure(4, 16, wpe_pkg::MODE_FWD);
        send_request(wpe_pkg::OP_SCHED, 0, 0, res);
        for (int i = 0; i < 4; i++)
            send_request(wpe_pkg::OP_MARK, 0, i, res);
        // Map full but all inside the window: no eviction.
        send_request(wpe_pkg::OP_SCHED, 0, 0, res);
        // Window moved away: the farthest loaded entry goes.
        send_request(wpe_pkg::OP_SCHED, 10, 0, res);
        send_request(wpe_pkg::OP_MARK, 0, 15, res);
        send_request(wpe_pkg::OP_RELEASE, 0, 15, res);
        send_request(wpe_pkg::OP_RELEASE, 0, 200, res);
        send_request(wpe_pkg::OP_MARK, 0, 200, res);
        // Position above the source count is clamped; search runs backward.
        send_request(wpe_pkg::OP_SCHED, 256, 0, res);
        send_request(wpe_pkg::OP_CLEAR, 0, 0, res);
    endtask

    task automatic test_directed_centered_and_stale();
        placement_t res;
        configure(256, 256, wpe_pkg::MODE_CENT);
        send_request(wpe_pkg::OP_MARK, 0, 255, res);
        send_request(wpe_pkg::OP_MARK, 0, 128, res);
        send_request(wpe_pkg::OP_SCHED, 256, 0, res);
        send_request(wpe_pkg::OP_SCHED, 0, 0, res);
        // Entries above the lowered count stay loaded and are eviction candidates.
        configure(2, 8, wpe_pkg::MODE_CENT);
        send_request(wpe_pkg::OP_SCHED, 4, 0, res);
        send_request(wpe_pkg::OP_RELEASE, 0, 255, res);
    endtask

    task automatic test_corner_modes();
        placement_t res;
        configure(3, 8, wpe_pkg::MODE_BWD);
        send_request(wpe_pkg::OP_SCHED, 5, 0, res);
        configure(0, 0, wpe_pkg::MODE_FWD);
        send_request(wpe_pkg::OP_SCHED, 0, 0, res);
        configure(0, 8, MODE_CENT_ALT);
        send_request(wpe_pkg::OP_SCHED, 3, 0, res);
        configure(3, 8, MODE_CENT_ALT);
        send_request(wpe_pkg::OP_SCHED, 7, 0, res);
    endtask

    // A random setting followed by mostly schedule-then-mark sequences.
    task automatic run_random_block(input int n_items);
        placement_t res;
        int r, cnt, lim, next_mark, ent;
        logic [1:0] mode;
        r = $urandom_range(9);
        if (r == 0)
        begin
            cnt = 256;
            lim = $urandom_range(1) ? 256 : $urandom_range(256);
        end
        else if (r == 1)
        begin
            cnt = $urandom_range(256);
            lim = $urandom_range(1);
        end
        else
        begin
            cnt = $urandom_range(1, 40);
            lim = $urandom_range(cnt + 3);
        end
        r = $urandom_range(9);
        mode = (r < 4) ? wpe_pkg::MODE_FWD :
               (r < 8) ? wpe_pkg::MODE_CENT :
               (r == 8) ? wpe_pkg::MODE_BWD : MODE_CENT_ALT;
        configure(lim, cnt, mode);
        next_mark = -1;
        for (int n = 0; n < n_items; n++)
        begin
            r = $urandom_range(99);
            if (next_mark >= 0 && r < 80)
            begin
                send_request(wpe_pkg::OP_MARK, $urandom_range(256), next_mark, res);
                next_mark = -1;
            end
            else
            begin
                r = $urandom_range(99);
                ent = (cnt > 0 && r % 4 != 0) ? $urandom_range(cnt - 1) : $urandom_range(255);
                if (r < 45)
                begin
                    send_request(wpe_pkg::OP_SCHED, pick_position(cnt), $urandom_range(255),
                                 res);
                    next_mark = res.load_found ? res.load_index : -1;
                end
                else if (r < 70)
                    send_request(wpe_pkg::OP_MARK, $urandom_range(256), ent, res);
                else if (r < 96)
                    send_request(wpe_pkg::OP_RELEASE, $urandom_range(256), ent, res);
                else
                    send_request(wpe_pkg::OP_CLEAR, $urandom_range(256), $urandom_range(255),
                                 res);
            end
        end
    endtask

    task automatic test_random(input int src_pct, input int snk_pct, input int n_blocks);
        source_idle_pct = src_pct;
        sink_idle_pct = snk_pct;
        for (int b = 0; b < n_blocks; b++)
            run_random_block(25);
    endtask

    task automatic test_backpressure();
        placement_t res;
        source_idle_pct = 0;
        sink_idle_pct = 0;
        configure(6, 20, wpe_pkg::MODE_FWD);
        holds_asked++;
        for (int n = 0; n < 12; n++)
        begin
            send_request(wpe_pkg::OP_SCHED, $urandom_range(20), 0, res);
            if (res.load_found)
                send_request(wpe_pkg::OP_MARK, 0, res.load_index, res);
        end
        // Sender stops until every outstanding result is back, then resumes.
        drain_results();
        for (int n = 0; n < 8; n++)
        begin
            send_request(wpe_pkg::OP_SCHED, $urandom_range(20), 0, res);
            if (res.load_found)
                send_request(wpe_pkg::OP_MARK, 0, res.load_index, res);
        end
    endtask

    always @(posedge clk)
    begin
        if (holds_served != holds_asked)
        begin
            holds_served = holds_asked;
            stall_left = LONG_HOLD;
        end
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_placements.size() == 0)
                report_mismatch("result with no request pending");
            else
            begin
                want = expected_placements.pop_front();
                if (m_axis_tdata[0] !== want.load_found)
                    report_mismatch($sformatf("load_found got %b want %b",
                                              m_axis_tdata[0], want.load_found));
                if (m_axis_tdata[8:1] !== want.load_index)
                    report_mismatch($sformatf("load_index got %0d want %0d",
                                              m_axis_tdata[8:1], want.load_index));
                if (m_axis_tdata[9] !== want.evict_found)
                    report_mismatch($sformatf("evict_found got %b want %b",
                                              m_axis_tdata[9], want.evict_found));
                if (m_axis_tdata[17:10] !== want.evict_index)
                    report_mismatch($sformatf("evict_index got %0d want %0d",
                                              m_axis_tdata[17:10], want.evict_index));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_forward();
        test_directed_centered_and_stale();
        test_corner_modes();
        test_random(23, 68, 8);
        test_random(68, 23, 8);
        test_backpressure();
        test_random(0, 0, 7);
        drain_results();
        repeat (16) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> window_prefetch_evict_policy.f
rtl/core/wpe_pkg.sv
rtl/core/wpe_ram.sv
rtl/core/wpe_window.sv
rtl/core/window_prefetch_evict_policy.sv
rtl/core/wpe_checker.sv
sim/tb.sv
